// File: src/polyline_nearest_point_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the polyline nearest point core
// Shared property wrappers; every property is sampled on aclk and is off
// while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef POLYLINE_NEAREST_POINT_CORE_ASSERT_SVH
`define POLYLINE_NEAREST_POINT_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PNP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PNP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/pnp_pkg.sv
// ----------------------------------------------------------------------------
// pnp_pkg
// Shared constants, codes and types of the polyline nearest point core.
// ----------------------------------------------------------------------------
package pnp_pkg;

    // Default table depth.
    localparam int MAX_VERTICES_DEF = 256;

    // Operation codes carried on s_tuser.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        CFG_VERTEX_COUNT = 1'b0,
        CFG_TOTAL_LENGTH = 1'b1
    } cfg_idx_t;

    // Saturation limits of the result fields.
    localparam logic [31:0] DIST_SAT = 32'hFFFF_FFFF;
    localparam logic [39:0] ARC_SAT  = 40'hFF_FFFF_FFFF;
    localparam logic [22:0] PCT_MAX  = 23'd6553600;

    // Datapath widths.
    localparam int MW   = 33;   // multiplier operand width
    localparam int PW   = 2 * MW;
    localparam int ACCW = 68;   // sum of three products, divider and root width
    localparam int DVDW = 64;   // dividend bits shifted into the divider

    // Step counts of the divide / root unit.
    localparam logic [6:0] SQRT_STEPS = 7'd34;
    localparam logic [6:0] T_STEPS    = 7'd32;
    localparam logic [6:0] PCT_STEPS  = 7'd64;

    typedef enum logic {
        DS_DIV  = 1'b0,
        DS_SQRT = 1'b1
    } ds_mode_t;

    // Command from the sequencer to the divide / root unit.
    typedef struct packed {
        logic       start;
        ds_mode_t   mode;
        logic [6:0] steps;
    } ds_cmd_t;

endpackage

// File: src/polyline_nearest_point_core.sv
// ----------------------------------------------------------------------------
// polyline_nearest_point_core
// Nearest point, distance and arc position of a 3-D point on a polyline.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one beat either writes a vertex (s_tuser = 0) into the table
//   slot vertex_index or asks a query (s_tuser = 1) for the point in tdata.
//   m_ channel: one beat per query with the closest point, distance, arc
//   length, percentage and segment index; m_tuser is the found flag.
//   cfg_ channel: writes vertex_count (index 0) or total_length (index 1); the
//   user must do so only while the core is idle, which the core does not enforce. It is always ready.
// Timing:
//   A query walks the segments one after another through one 33x33 multiplier
//   and one shared divide / root unit that yields one bit per cycle. Each
//   segment steps and fetches its end points, then runs 13 multiplies, a
//   34-step root and a 32-step divide, then bookkeeping; the divide is
//   skipped when the parameter clamps, and a degenerate segment stops after
//   the squared length and dot product. The query ends with a final root and
//   the 64-step percentage divide. s_tready is low for the whole query.
// Reset and stall:
//   aresetn clears control and configuration; the datapath registers and
//   the table stay undefined until written. A finished result waits in the
//   output register while m_tready is low; the core still takes new beats,
//   and a second result waits inside until the output register frees up.
// ----------------------------------------------------------------------------
module polyline_nearest_point_core #(
    parameter int MAX_VERTICES = pnp_pkg::MAX_VERTICES_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    // Input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [103:0] s_tdata,   // vertex_index[7:0], coord_x, coord_y, coord_z
    input  logic         s_tuser,   // op
    // Result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [199:0] m_tdata,   // near_x, near_y, near_z, radial_distance,
                                    // arc_length, percent_along, segment_number, pad
    output logic         m_tuser,   // found
    // Configuration writes
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [0:0]   cfg_index,
    input  logic [39:0]  cfg_data
);

    localparam int AW   = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CW   = $clog2(MAX_VERTICES + 1);
    localparam int MW   = pnp_pkg::MW;
    localparam int PW   = pnp_pkg::PW;
    localparam int ACCW = pnp_pkg::ACCW;

    typedef enum logic [4:0] {
        S_IDLE, S_LOOP, S_RD_A, S_RD_B, S_RD_C, S_MUL_A, S_CHK, S_WAIT_LEN,
        S_TSEL, S_WAIT_T, S_MUL_B, S_UPDATE, S_FIN, S_WAIT_DIST, S_PCT,
        S_WAIT_PCT, S_OUT
    } state_t;

    state_t state_reg;

    // Configuration registers.
    logic [8:0]  vc_reg;
    logic [39:0] total_reg;

    // Query and segment registers.
    logic [CW-1:0]        i_reg;
    logic signed [31:0]   p_reg  [3];
    logic signed [31:0]   v0_reg [3];
    logic [MW-1:0]        em_reg [3];
    logic                 esn_reg[3];
    logic [MW-1:0]        am_reg [3];
    logic                 sx_reg [3];
    logic [31:0]          q_reg  [3];
    logic [MW-1:0]        dm_reg [3];
    logic [ACCW-1:0]      len2_reg, pos_reg, neg_reg, d2_reg;
    logic [MW-1:0]        len_reg;
    logic [MW-1:0]        t_reg;
    logic [33:0]          arcf_reg;
    logic [41:0]          cum_reg;
    logic [2:0]           mj_reg;
    logic [1:0]           mph_reg;

    // Best candidate so far.
    logic                 found_reg;
    logic [ACCW-1:0]      bd2_reg;
    logic [31:0]          bq_reg [3];
    logic [41:0]          barc_reg;
    logic [7:0]           bseg_reg;

    // Finished result and output register.
    logic [31:0]          rdist_reg;
    logic [39:0]          rarc_reg;
    logic [22:0]          rpct_reg;
    logic                 m_tvalid_reg;
    logic [199:0]         m_tdata_reg;
    logic                 m_tuser_reg;
    logic                 out_load_w;

    // Multiplier.
    logic [MW-1:0]        mul_a_reg, mul_b_reg;
    logic [PW-1:0]        prod_reg;

    // Divide / root command.
    logic                 ds_start_reg;
    pnp_pkg::ds_mode_t    ds_mode_reg;
    logic [6:0]           ds_steps_reg;
    logic [ACCW-1:0]      ds_a_reg, ds_dvs_reg;
    logic [pnp_pkg::DVDW-1:0] ds_dvd_reg;
    pnp_pkg::ds_cmd_t     ds_cmd;
    logic                 ds_done;
    logic [ACCW-1:0]      ds_result;

    // Input fields.
    logic [7:0]           s_index;
    logic signed [31:0]   s_coord [3];

    // Table port.
    logic                 ram_we, ram_re;
    logic [AW-1:0]        ram_waddr, ram_raddr;
    logic [95:0]          ram_rdata;

    // Combinational helpers.
    logic [CW-1:0]        n_w;
    logic [CW-1:0]        ip1_w;
    logic [CW:0]          ip1_ext;
    logic [1:0]           k_w;
    logic signed [32:0]   e_w [3];
    logic signed [32:0]   a_w [3];
    logic [PW:0]          rnd_w;
    logic [33:0]          rs_w;
    logic signed [35:0]   qf_w, df_w;
    logic [35:0]          dmag_w;
    logic [ACCW-1:0]      num_w;
    logic [39:0]          arcsat_w;
    logic [44:0]          arc25_w;
    logic [31:0]          seg_ext;
    logic [31:0]          n_ext;

    assign s_index    = s_tdata[7:0];
    assign s_coord[0] = s_tdata[39:8];
    assign s_coord[1] = s_tdata[71:40];
    assign s_coord[2] = s_tdata[103:72];

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;

    // The finished result moves into the output register this cycle.
    assign out_load_w = (state_reg == S_OUT) && (!m_tvalid_reg || m_tready);

    // Table write on a vertex beat, read of the segment end points.
    assign ram_we    = s_tvalid && s_tready && (s_tuser == pnp_pkg::OP_WRITE)
                       && ({24'd0, s_index} < 32'(MAX_VERTICES));
    assign ram_waddr = AW'(s_index);
    assign ram_re    = (state_reg == S_RD_A) || (state_reg == S_RD_B);
    assign ram_raddr = (state_reg == S_RD_A) ? i_reg[AW-1:0] : ip1_w[AW-1:0];

    pnp_ram #(
        .WIDTH (96),
        .DEPTH (MAX_VERTICES)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata ({s_coord[2], s_coord[1], s_coord[0]}),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign ds_cmd = '{start: ds_start_reg, mode: ds_mode_reg, steps: ds_steps_reg};

    pnp_divsqrt u_divsqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (ds_cmd),
        .op_a     (ds_a_reg),
        .dividend (ds_dvd_reg),
        .divisor  (ds_dvs_reg),
        .done     (ds_done),
        .result   (ds_result)
    );

    // Segment count, edge vectors and the rounded product terms.
    always_comb begin
        n_ext   = (32'(vc_reg) > 32'(MAX_VERTICES)) ? 32'(MAX_VERTICES) : 32'(vc_reg);
        n_w     = n_ext[CW-1:0];
        ip1_w   = i_reg + CW'(1);
        ip1_ext = {1'b0, i_reg} + (CW+1)'(1);
        k_w     = mj_reg[2:1];
        seg_ext = 32'(i_reg);
        for (int k = 0; k < 3; k++) begin
            e_w[k] = 33'(signed'(ram_rdata[32*k +: 32])) - 33'(v0_reg[k]);
            a_w[k] = 33'(p_reg[k]) - 33'(v0_reg[k]);
        end
        rnd_w  = {1'b0, prod_reg} + (PW+1)'(64'h8000_0000);
        rs_w   = rnd_w[65:32];
        qf_w   = 36'(v0_reg[0]);
        df_w   = '0;
        if (k_w != 2'd3) begin
            qf_w = esn_reg[k_w] ? (36'(v0_reg[k_w]) - signed'({2'b00, rs_w}))
                                : (36'(v0_reg[k_w]) + signed'({2'b00, rs_w}));
            df_w = 36'(p_reg[k_w]) - qf_w;
        end
        dmag_w   = df_w[35] ? 36'(-df_w) : 36'(df_w);
        num_w    = pos_reg - neg_reg;
        arcsat_w = (barc_reg > {2'b00, pnp_pkg::ARC_SAT}) ? pnp_pkg::ARC_SAT : barc_reg[39:0];
        arc25_w  = {1'b0, rarc_reg, 4'b0} + {2'b00, rarc_reg, 3'b0} + {5'b0, rarc_reg};
    end

    // Multiplier stage.
    always_ff @(posedge aclk) begin
        prod_reg <= mul_a_reg * mul_b_reg;
    end

    // Sequencer, datapath registers and output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            vc_reg       <= '0;
            total_reg    <= '0;
            found_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
            ds_start_reg <= 1'b0;
        end else begin
            // Configuration writes.
            if (cfg_valid) begin
                case (pnp_pkg::cfg_idx_t'(cfg_index))
                    pnp_pkg::CFG_VERTEX_COUNT: vc_reg    <= cfg_data[8:0];
                    pnp_pkg::CFG_TOTAL_LENGTH: total_reg <= cfg_data;
                    default: ;
                endcase
            end

            // Output register: load a new result or retire the taken beat.
            if (out_load_w) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid && (s_tuser == pnp_pkg::OP_QUERY)) begin
                        for (int k = 0; k < 3; k++) p_reg[k] <= s_coord[k];
                        i_reg     <= '0;
                        cum_reg   <= '0;
                        found_reg <= 1'b0;
                        state_reg <= S_LOOP;
                    end
                end

                // Next segment, or wrap up.
                S_LOOP: begin
                    if (ip1_ext < {1'b0, n_w}) state_reg <= S_RD_A;
                    else                       state_reg <= S_FIN;
                end

                S_RD_A: state_reg <= S_RD_B;

                S_RD_B: begin
                    for (int k = 0; k < 3; k++) v0_reg[k] <= ram_rdata[32*k +: 32];
                    state_reg <= S_RD_C;
                end

                // Edge and offset magnitudes and signs.
                S_RD_C: begin
                    for (int k = 0; k < 3; k++) begin
                        em_reg[k]  <= e_w[k][32] ? 33'(-e_w[k]) : 33'(e_w[k]);
                        esn_reg[k] <= e_w[k][32];
                        am_reg[k]  <= a_w[k][32] ? 33'(-a_w[k]) : 33'(a_w[k]);
                        sx_reg[k]  <= a_w[k][32] ^ e_w[k][32];
                    end
                    len2_reg  <= '0;
                    pos_reg   <= '0;
                    neg_reg   <= '0;
                    d2_reg    <= '0;
                    mj_reg    <= '0;
                    mph_reg   <= '0;
                    state_reg <= S_MUL_A;
                end

                // Squared length and the signed dot product.
                S_MUL_A: begin
                    case (mph_reg)
                        2'd0: begin
                            mul_a_reg <= mj_reg[0] ? am_reg[k_w] : em_reg[k_w];
                            mul_b_reg <= em_reg[k_w];
                            mph_reg   <= 2'd1;
                        end
                        2'd1: mph_reg <= 2'd2;
                        default: begin
                            if (!mj_reg[0])         len2_reg <= len2_reg + ACCW'(prod_reg);
                            else if (sx_reg[k_w])   neg_reg  <= neg_reg + ACCW'(prod_reg);
                            else                    pos_reg  <= pos_reg + ACCW'(prod_reg);
                            mph_reg <= 2'd0;
                            if (mj_reg == 3'd5) state_reg <= S_CHK;
                            else                mj_reg    <= mj_reg + 3'd1;
                        end
                    endcase
                end

                // Degenerate segments add nothing.
                S_CHK: begin
                    if (len2_reg == '0) begin
                        i_reg     <= ip1_w;
                        state_reg <= S_LOOP;
                    end else begin
                        ds_start_reg <= 1'b1;
                        ds_mode_reg  <= pnp_pkg::DS_SQRT;
                        ds_steps_reg <= pnp_pkg::SQRT_STEPS;
                        ds_a_reg     <= len2_reg;
                        state_reg    <= S_WAIT_LEN;
                    end
                end

                S_WAIT_LEN: begin
                    ds_start_reg <= 1'b0;
                    if (ds_done) begin
                        len_reg   <= ds_result[MW-1:0];
                        state_reg <= S_TSEL;
                    end
                end

                // Clamped projection parameter.
                S_TSEL: begin
                    mj_reg  <= '0;
                    mph_reg <= '0;
                    if (pos_reg <= neg_reg) begin
                        t_reg     <= '0;
                        state_reg <= S_MUL_B;
                    end else if (num_w >= len2_reg) begin
                        t_reg     <= {1'b1, 32'd0};
                        state_reg <= S_MUL_B;
                    end else begin
                        ds_start_reg <= 1'b1;
                        ds_mode_reg  <= pnp_pkg::DS_DIV;
                        ds_steps_reg <= pnp_pkg::T_STEPS;
                        ds_a_reg     <= num_w;
                        ds_dvd_reg   <= '0;
                        ds_dvs_reg   <= len2_reg;
                        state_reg    <= S_WAIT_T;
                    end
                end

                S_WAIT_T: begin
                    ds_start_reg <= 1'b0;
                    if (ds_done) begin
                        t_reg     <= {1'b0, ds_result[31:0]};
                        state_reg <= S_MUL_B;
                    end
                end

                // Closest point, squared distance and partial arc.
                S_MUL_B: begin
                    case (mph_reg)
                        2'd0: begin
                            if (mj_reg == 3'd6) begin
                                mul_a_reg <= t_reg;
                                mul_b_reg <= len_reg;
                            end else if (!mj_reg[0]) begin
                                mul_a_reg <= em_reg[k_w];
                                mul_b_reg <= t_reg;
                            end else begin
                                mul_a_reg <= dm_reg[k_w];
                                mul_b_reg <= dm_reg[k_w];
                            end
                            mph_reg <= 2'd1;
                        end
                        2'd1: mph_reg <= 2'd2;
                        default: begin
                            mph_reg <= 2'd0;
                            if (mj_reg == 3'd6) begin
                                arcf_reg  <= rs_w;
                                state_reg <= S_UPDATE;
                            end else begin
                                if (!mj_reg[0]) begin
                                    q_reg[k_w]  <= qf_w[31:0];
                                    dm_reg[k_w] <= dmag_w[MW-1:0];
                                end else begin
                                    d2_reg <= d2_reg + ACCW'(prod_reg);
                                end
                                mj_reg <= mj_reg + 3'd1;
                            end
                        end
                    endcase
                end

                // Keep the strictly nearest segment.
                S_UPDATE: begin
                    if (!found_reg || (d2_reg < bd2_reg)) begin
                        found_reg <= 1'b1;
                        bd2_reg   <= d2_reg;
                        for (int k = 0; k < 3; k++) bq_reg[k] <= q_reg[k];
                        barc_reg  <= cum_reg + 42'(arcf_reg);
                        bseg_reg  <= seg_ext[7:0];
                    end
                    cum_reg   <= cum_reg + 42'(len_reg);
                    i_reg     <= ip1_w;
                    state_reg <= S_LOOP;
                end

                // Distance of the winner, or the empty result.
                S_FIN: begin
                    if (!found_reg) begin
                        for (int k = 0; k < 3; k++) bq_reg[k] <= '0;
                        bseg_reg  <= '0;
                        rdist_reg <= pnp_pkg::DIST_SAT;
                        rarc_reg  <= '0;
                        rpct_reg  <= '0;
                        state_reg <= S_OUT;
                    end else begin
                        ds_start_reg <= 1'b1;
                        ds_mode_reg  <= pnp_pkg::DS_SQRT;
                        ds_steps_reg <= pnp_pkg::SQRT_STEPS;
                        ds_a_reg     <= bd2_reg;
                        rarc_reg     <= arcsat_w;
                        state_reg    <= S_WAIT_DIST;
                    end
                end

                S_WAIT_DIST: begin
                    ds_start_reg <= 1'b0;
                    if (ds_done) begin
                        rdist_reg <= (ds_result > ACCW'(pnp_pkg::DIST_SAT))
                                     ? pnp_pkg::DIST_SAT : ds_result[31:0];
                        state_reg <= S_PCT;
                    end
                end

                // Percentage: arc * 100 * 2^16 / total_length.
                S_PCT: begin
                    if (total_reg == '0) begin
                        rpct_reg  <= '0;
                        state_reg <= S_OUT;
                    end else begin
                        ds_start_reg <= 1'b1;
                        ds_mode_reg  <= pnp_pkg::DS_DIV;
                        ds_steps_reg <= pnp_pkg::PCT_STEPS;
                        ds_a_reg     <= '0;
                        ds_dvd_reg   <= {1'b0, arc25_w, 18'd0};
                        ds_dvs_reg   <= ACCW'(total_reg);
                        state_reg    <= S_WAIT_PCT;
                    end
                end

                S_WAIT_PCT: begin
                    ds_start_reg <= 1'b0;
                    if (ds_done) begin
                        rpct_reg  <= (ds_result > ACCW'(pnp_pkg::PCT_MAX))
                                     ? pnp_pkg::PCT_MAX : ds_result[22:0];
                        state_reg <= S_OUT;
                    end
                end

                // Hand the result to the output register once it is free.
                S_OUT: begin
                    if (out_load_w) begin
                        m_tdata_reg  <= {1'b0, bseg_reg, rpct_reg, rarc_reg, rdist_reg,
                                         bq_reg[2], bq_reg[1], bq_reg[0]};
                        m_tuser_reg  <= found_reg;
                        state_reg    <= S_IDLE;
                    end
                end

                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// File: src/pnp_ram.sv
// ----------------------------------------------------------------------------
// pnp_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module pnp_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 256
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: src/pnp_divsqrt.sv
// ----------------------------------------------------------------------------
// pnp_divsqrt
// Shared iterative unit: restoring long division or bit-pair square root,
// one result bit per cycle.
// ----------------------------------------------------------------------------
module pnp_divsqrt (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  pnp_pkg::ds_cmd_t            cmd,
    input  logic [pnp_pkg::ACCW-1:0]    op_a,      // initial remainder or radicand
    input  logic [pnp_pkg::DVDW-1:0]    dividend,  // bits shifted in, MSB first
    input  logic [pnp_pkg::ACCW-1:0]    divisor,
    output logic                        done,
    output logic [pnp_pkg::ACCW-1:0]    result
);

    localparam int AW = pnp_pkg::ACCW;

    logic                        busy_reg;
    logic                        done_reg;
    logic [6:0]                  cnt_reg;
    pnp_pkg::ds_mode_t           mode_reg;
    logic [AW-1:0]               rem_reg, rem_next;
    logic [AW-1:0]               quo_reg, quo_next;
    logic [AW-1:0]               one_reg;
    logic [AW-1:0]               dvs_reg;
    logic [pnp_pkg::DVDW-1:0]    dsh_reg;

    logic [AW-1:0] shifted;
    logic [AW:0]   trial;
    logic          ge;

    // One step of the selected recurrence.
    always_comb begin
        shifted  = {rem_reg[AW-2:0], dsh_reg[pnp_pkg::DVDW-1]};
        trial    = {1'b0, quo_reg} + {1'b0, one_reg};
        rem_next = rem_reg;
        quo_next = quo_reg;
        ge       = 1'b0;
        if (mode_reg == pnp_pkg::DS_DIV) begin
            ge       = (shifted >= dvs_reg);
            rem_next = ge ? (shifted - dvs_reg) : shifted;
            quo_next = {quo_reg[AW-2:0], ge};
        end else begin
            ge       = ({1'b0, rem_reg} >= trial);
            rem_next = ge ? (rem_reg - trial[AW-1:0]) : rem_reg;
            quo_next = ge ? ((quo_reg >> 1) + one_reg) : (quo_reg >> 1);
        end
    end

    // Step counter and working registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (cmd.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= cmd.steps;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            mode_reg <= cmd.mode;
            rem_reg  <= op_a;
            quo_reg  <= '0;
            one_reg  <= {2'b01, {(AW-2){1'b0}}};
            dvs_reg  <= divisor;
            dsh_reg  <= dividend;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
            one_reg <= one_reg >> 2;
            dsh_reg <= dsh_reg << 1;
        end
    end

    assign done   = done_reg;
    assign result = quo_reg;

endmodule

// File: src/pnp_checker.sv
// ----------------------------------------------------------------------------
// pnp_checker
// Port-level checks of the polyline nearest point core, bound to the top.
// ----------------------------------------------------------------------------
`include "polyline_nearest_point_core_assert.svh"

module pnp_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [103:0] s_tdata,
    input logic         s_tuser,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [199:0] m_tdata,
    input logic         m_tuser,
    input logic         cfg_valid,
    input logic         cfg_ready,
    input logic [0:0]   cfg_index,
    input logic [39:0]  cfg_data
);

    // A stalled result beat keeps its payload.
    `PNP_ASSERT_NXT(a_m_hold, m_tvalid && !m_tready, $stable(m_tdata) && m_tvalid, "result beat changed while stalled")

    // A query keeps the input side closed on the next cycle.
    `PNP_ASSERT_NXT(a_query_busy, s_tvalid && s_tready && s_tuser, !s_tready, "input ready right after a query")

    // A vertex write never makes a result appear.
    `PNP_ASSERT_NXT(a_write_silent, s_tvalid && s_tready && !s_tuser && !m_tvalid, !m_tvalid, "result after a vertex write")

    // An empty result carries the saturated distance and zero position.
    `PNP_ASSERT_NOW(a_empty_result, m_tvalid && !m_tuser, (m_tdata[127:96] == 32'hFFFF_FFFF) && (m_tdata[95:0] == 96'd0), "bad empty result")

endmodule

bind polyline_nearest_point_core pnp_checker u_pnp_checker (.*);
